// ===== hw/rtl/ztt_pkg.sv =====
// shared types and constants for the zobrist transposition table
// no dependencies

package ztt_pkg;

   localparam int HASH_BITS  = 64;
   localparam int SCORE_BITS = 16;
   localparam int DEPTH_BITS = 8;

   typedef enum logic [1:0] {
      REQ_LOAD  = 2'd0,
      REQ_STORE = 2'd1,
      REQ_PROBE = 2'd2,
      REQ_NONE  = 2'd3
   } ztt_req_kind_type;

   typedef struct packed {
      logic                          write;
      logic                          read;
      logic [5:0]                    square;
      logic [3:0]                    piece;
      logic                          color;
      logic [HASH_BITS-1:0]          value;
   } ztt_mask_cmd_type;

   typedef struct packed {
      logic                          write;
      logic                          read;
      logic [HASH_BITS-1:0]          hash;
      logic signed [SCORE_BITS-1:0]  score;
      logic [DEPTH_BITS-1:0]         depth;
   } ztt_tbl_cmd_type;

   typedef struct packed {
      logic [HASH_BITS-1:0]          tag;
      logic signed [SCORE_BITS-1:0]  score;
      logic [DEPTH_BITS-1:0]         depth;
   } ztt_entry_type;

endpackage

// ===== hw/rtl/ztt_ifs.sv =====
// valid/ready channel interfaces for request and response items
// no dependencies

interface ztt_req_if;
   logic               valid;
   logic               ready;
   logic [1:0]         req_type;
   logic [5:0]         square;
   logic [3:0]         piece;
   logic               color;
   logic               last_square;
   logic [63:0]        mask_value;
   logic signed [15:0] score;
   logic [7:0]         search_depth;

   modport source (
      output valid, req_type, square, piece, color, last_square, mask_value, score,
         search_depth,
      input  ready
   );
   modport sink (
      input  valid, req_type, square, piece, color, last_square, mask_value, score,
         search_depth,
      output ready
   );
endinterface

interface ztt_rsp_if;
   logic               valid;
   logic               ready;
   logic               found;
   logic [63:0]        entry_hash;
   logic signed [15:0] entry_score;
   logic [7:0]         entry_depth;

   modport source (
      output valid, found, entry_hash, entry_score, entry_depth,
      input  ready
   );
   modport sink (
      input  valid, found, entry_hash, entry_score, entry_depth,
      output ready
   );
endinterface

// ===== hw/rtl/zobrist_transposition_table.sv =====
// zobrist position hash with a direct-mapped, always-replace transposition table
// depends on ztt_pkg, ztt_ifs, ztt_mask_mem and ztt_table
//
// req carries three kinds of item: mask loads, which fill the mask word for
// one (square, piece, color), and square items of a position to store or to
// probe. each square item xors its mask into a running hash; the item marked
// last_square writes (hash, score, depth) into the table or probes it.
// rsp gives one item per probe: found, the full hash and the stored score and
// depth (zero on a miss). stores and loads give no response.
// throughput is one item per cycle outside the sweep and stalls below, set by
// the registered mask memory read and the running hash xor. a probe response
// passes the mask read, then the table read, then the output register.
// after reset the table is swept to zero at one entry per cycle, and req.ready
// stays low until the sweep ends; mask words are undefined until loaded.
// when rsp stalls, the response and one further probe are held; store and
// load items keep flowing, and the last square of a third probe waits in the
// square stage, holding req.ready low, until the held probe moves on.

module zobrist_transposition_table #(
   parameter int INDEX_BITS  = 16,
   parameter int PIECE_CODES = 9,
   parameter int SQUARES     = 64
) (
   input  logic        clock,
   input  logic        reset,
   ztt_req_if.sink     req,
   ztt_rsp_if.source   rsp
);
   import ztt_pkg::*;

   ztt_mask_cmd_type mask_cmd;
   ztt_tbl_cmd_type  tbl_cmd;
   ztt_entry_type    tbl_entry;
   logic [HASH_BITS-1:0] mask;
   logic                 clearing;

   logic                         accept;
   logic                         is_square;
   logic                         s1_valid_ff, s1_valid_in;
   logic                         s1_probe_ff;
   logic                         s1_last_ff;
   logic signed [SCORE_BITS-1:0] s1_score_ff;
   logic [DEPTH_BITS-1:0]        s1_depth_ff;
   logic [HASH_BITS-1:0]         s1_hash;
   logic                         s1_adv;
   logic                         s1_free;
   logic [HASH_BITS-1:0]         running_hash_ff, running_hash_in;
   logic                         s2_valid_ff, s2_valid_in;
   logic [HASH_BITS-1:0]         s2_hash_ff;
   logic                         s2_free;
   logic                         out_free;
   logic                         out_valid_ff, out_valid_in;
   logic                         out_found_ff;
   logic [HASH_BITS-1:0]         out_hash_ff;
   logic signed [SCORE_BITS-1:0] out_score_ff;
   logic [DEPTH_BITS-1:0]        out_depth_ff;
   logic                         hit;
   logic                         out_load;

   ztt_mask_mem #(
      .SQUARES     (SQUARES),
      .PIECE_CODES (PIECE_CODES)
   ) u_mask_mem (
      .clock (clock),
      .reset (reset),
      .cmd   (mask_cmd),
      .mask  (mask)
   );

   ztt_table #(
      .INDEX_BITS (INDEX_BITS)
   ) u_table (
      .clock    (clock),
      .reset    (reset),
      .cmd      (tbl_cmd),
      .rd_entry (tbl_entry),
      .clearing (clearing)
   );

   always_comb begin
      accept    = req.valid && req.ready;
      is_square = (ztt_req_kind_type'(req.req_type) == REQ_STORE)
         || (ztt_req_kind_type'(req.req_type) == REQ_PROBE);

      mask_cmd.write  = accept && (ztt_req_kind_type'(req.req_type) == REQ_LOAD);
      mask_cmd.read   = accept && is_square;
      mask_cmd.square = req.square;
      mask_cmd.piece  = req.piece;
      mask_cmd.color  = req.color;
      mask_cmd.value  = req.mask_value;

      out_free = !out_valid_ff || rsp.ready;
      s2_free  = !s2_valid_ff || out_free;
      s1_hash  = running_hash_ff ^ mask;
      s1_adv   = s1_valid_ff && (!(s1_last_ff && s1_probe_ff) || s2_free);
      s1_free  = !s1_valid_ff || s1_adv;

      tbl_cmd.write = s1_adv && s1_last_ff && !s1_probe_ff;
      tbl_cmd.read  = s1_adv && s1_last_ff && s1_probe_ff;
      tbl_cmd.hash  = s1_hash;
      tbl_cmd.score = s1_score_ff;
      tbl_cmd.depth = s1_depth_ff;

      running_hash_in = running_hash_ff;
      if (s1_adv) begin
         running_hash_in = s1_last_ff ? '0 : s1_hash;
      end

      s1_valid_in = s1_valid_ff;
      if (s1_free) begin
         s1_valid_in = accept && is_square;
      end

      out_load = s2_valid_ff && out_free;

      s2_valid_in = s2_valid_ff;
      if (tbl_cmd.read) begin
         s2_valid_in = 1'b1;
      end else if (out_load) begin
         s2_valid_in = 1'b0;
      end

      out_valid_in = out_valid_ff;
      if (out_load) begin
         out_valid_in = 1'b1;
      end else if (rsp.ready) begin
         out_valid_in = 1'b0;
      end

      hit = (tbl_entry.tag == s2_hash_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff     <= 1'b0;
         s2_valid_ff     <= 1'b0;
         out_valid_ff    <= 1'b0;
         running_hash_ff <= '0;
      end else begin
         s1_valid_ff     <= s1_valid_in;
         s2_valid_ff     <= s2_valid_in;
         out_valid_ff    <= out_valid_in;
         running_hash_ff <= running_hash_in;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_free) begin
         s1_probe_ff <= (ztt_req_kind_type'(req.req_type) == REQ_PROBE);
         s1_last_ff  <= req.last_square;
         s1_score_ff <= req.score;
         s1_depth_ff <= req.search_depth;
      end
      if (tbl_cmd.read) begin
         s2_hash_ff <= s1_hash;
      end
      if (out_load) begin
         out_found_ff <= hit;
         out_hash_ff  <= s2_hash_ff;
         out_score_ff <= hit ? tbl_entry.score : '0;
         out_depth_ff <= hit ? tbl_entry.depth : '0;
      end
   end

   assign req.ready       = s1_free && !clearing;
   assign rsp.valid       = out_valid_ff;
   assign rsp.found       = out_found_ff;
   assign rsp.entry_hash  = out_hash_ff;
   assign rsp.entry_score = out_score_ff;
   assign rsp.entry_depth = out_depth_ff;

   assert property (@(posedge clock) disable iff (reset)
      tbl_cmd.read |-> s2_free)
      else $error("table read would overwrite a pending probe");

   assert property (@(posedge clock) disable iff (reset)
      (s2_valid_ff && !out_free) |=> (s2_valid_ff && $stable(s2_hash_ff)))
      else $error("pending probe lost while response stalled");

   assert property (@(posedge clock) disable iff (reset)
      (s1_adv && s1_last_ff) |=> (running_hash_ff == '0))
      else $error("running hash not cleared after last square");

   assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && !s1_adv) |=> ($stable(mask) && $stable(running_hash_ff)))
      else $error("stalled square lost its mask or hash");

endmodule

// ===== hw/rtl/ztt_mask_mem.sv =====
// mask word memory indexed by square, piece code and color
// depends on ztt_pkg

module ztt_mask_mem #(
   parameter int SQUARES     = 64,
   parameter int PIECE_CODES = 9
) (
   input  logic                           clock,
   input  logic                           reset,
   input  ztt_pkg::ztt_mask_cmd_type      cmd,
   output logic [ztt_pkg::HASH_BITS-1:0]  mask
);
   import ztt_pkg::*;

   localparam int MASK_COUNT = SQUARES * PIECE_CODES * 2;
   localparam int SLOT_BITS  = $clog2(MASK_COUNT);
   localparam logic [6:0] SQ_LIMIT = 7'(SQUARES);
   localparam logic [4:0] PC_LIMIT = 5'(PIECE_CODES);

   logic [HASH_BITS-1:0] mask_mem [MASK_COUNT];
   logic [HASH_BITS-1:0] rd_data_ff;
   logic                 rd_ok_ff;
   logic                 rd_ok_in;
   logic                 in_range;
   logic [SLOT_BITS-1:0] slot;

   always_comb begin
      in_range = ({1'b0, cmd.square} < SQ_LIMIT) && ({1'b0, cmd.piece} < PC_LIMIT);
      slot = SLOT_BITS'((SLOT_BITS'(cmd.square) * SLOT_BITS'(PIECE_CODES)
         + SLOT_BITS'(cmd.piece)) * SLOT_BITS'(2) + SLOT_BITS'(cmd.color));
      rd_ok_in = rd_ok_ff;
      if (cmd.read) begin
         rd_ok_in = in_range;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.write && in_range) begin
         mask_mem[slot] <= cmd.value;
      end
      if (cmd.read && in_range) begin
         rd_data_ff <= mask_mem[slot];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_ok_ff <= 1'b0;
      end else begin
         rd_ok_ff <= rd_ok_in;
      end
   end

   // out-of-range squares and piece codes contribute nothing
   assign mask = rd_ok_ff ? rd_data_ff : '0;

   assert property (@(posedge clock) disable iff (reset)
      (cmd.read && !in_range) |=> (mask == '0))
      else $error("out-of-range square gave a nonzero mask");

endmodule

// ===== hw/rtl/ztt_table.sv =====
// direct-mapped entry memory with a clearing sweep after reset
// depends on ztt_pkg

module ztt_table #(
   parameter int INDEX_BITS = 16
) (
   input  logic                     clock,
   input  logic                     reset,
   input  ztt_pkg::ztt_tbl_cmd_type cmd,
   output ztt_pkg::ztt_entry_type   rd_entry,
   output logic                     clearing
);
   import ztt_pkg::*;

   localparam int TABLE_DEPTH = 1 << INDEX_BITS;

   ztt_entry_type   tbl_mem [TABLE_DEPTH];
   ztt_entry_type   rd_entry_ff;
   ztt_entry_type   wr_entry;
   logic [INDEX_BITS-1:0] clr_addr_ff;
   logic [INDEX_BITS-1:0] clr_addr_in;
   logic                  clr_busy_ff;
   logic                  clr_busy_in;
   logic [INDEX_BITS-1:0] idx;
   logic [INDEX_BITS-1:0] wr_idx;
   logic                  wr_en;

   always_comb begin
      idx = cmd.hash[INDEX_BITS-1:0];
      clr_addr_in = clr_addr_ff;
      clr_busy_in = clr_busy_ff;
      if (clr_busy_ff) begin
         clr_addr_in = clr_addr_ff + 1'b1;
         if (clr_addr_ff == '1) begin
            clr_busy_in = 1'b0;
         end
      end
      if (clr_busy_ff) begin
         wr_en    = 1'b1;
         wr_idx   = clr_addr_ff;
         wr_entry = '0;
      end else begin
         wr_en          = cmd.write;
         wr_idx         = idx;
         wr_entry.tag   = cmd.hash;
         wr_entry.score = cmd.score;
         wr_entry.depth = cmd.depth;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         tbl_mem[wr_idx] <= wr_entry;
      end
      if (cmd.read) begin
         rd_entry_ff <= tbl_mem[idx];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_busy_ff <= 1'b1;
         clr_addr_ff <= '0;
      end else begin
         clr_busy_ff <= clr_busy_in;
         clr_addr_ff <= clr_addr_in;
      end
   end

   assign rd_entry = rd_entry_ff;
   assign clearing = clr_busy_ff;

   assert property (@(posedge clock) disable iff (reset)
      $fell(clr_busy_ff) |-> ($past(clr_addr_ff) == '1))
      else $error("clearing sweep ended early");

   assert property (@(posedge clock) disable iff (reset)
      clr_busy_ff |-> !(cmd.read || cmd.write))
      else $error("table access during clearing sweep");

endmodule

// ===== tb/sv/ztt_probe_checker.sv =====
// checker for the zobrist transposition table: watches req and rsp, keeps its own
// mask words, running hash and table, and compares every probe response
// depends on ztt_pkg and ztt_ifs

module ztt_probe_checker #(
   parameter int INDEX_BITS  = 16,
   parameter int PIECE_CODES = 9,
   parameter int SQUARES     = 64
) (
   input  logic clock,
   input  logic reset,
   ztt_req_if   req,
   ztt_rsp_if   rsp,
   output int   errors,
   output int   pending
);
   timeunit 1ns;
   timeprecision 1ps;
   import ztt_pkg::*;

   localparam int MASK_WORDS = SQUARES * PIECE_CODES * 2;

   typedef struct packed {
      logic                         found;
      logic [HASH_BITS-1:0]         hash;
      logic signed [SCORE_BITS-1:0] score;
      logic [DEPTH_BITS-1:0]        depth;
   } probe_answer_type;

   logic [HASH_BITS-1:0] mask_words [MASK_WORDS];
   logic [HASH_BITS-1:0] position_hash;
   ztt_entry_type        table_mem [int];
   probe_answer_type     probe_answers [$];
   int                   error_count = 0;
   int                   answers_due = 0;

   assign errors  = error_count;
   assign pending = answers_due;

   function automatic int mask_slot(logic [5:0] sq, logic [3:0] pc, logic col);
      if (sq >= SQUARES || pc >= PIECE_CODES) return -1;
      return (int'(sq) * PIECE_CODES + int'(pc)) * 2 + int'(col);
   endfunction

   task automatic hash_and_lookup();
      logic [HASH_BITS-1:0] h;
      int                   slot;
      int                   idx;
      ztt_entry_type        e;
      probe_answer_type     a;
      slot = mask_slot(req.square, req.piece, req.color);
      if (req.req_type == REQ_LOAD) begin
         if (slot >= 0) mask_words[slot] = req.mask_value;
      end else if (req.req_type != REQ_NONE) begin
         h = position_hash;
         if (slot >= 0) h = h ^ mask_words[slot];
         if (!req.last_square) begin
            position_hash = h;
         end else begin
            position_hash = '0;
            idx = int'(h & ((64'd1 << INDEX_BITS) - 64'd1));
            if (req.req_type == REQ_STORE) begin
               table_mem[idx] = '{tag: h, score: req.score, depth: req.search_depth};
            end else begin
               e = table_mem.exists(idx) ? table_mem[idx] : '0;
               a.hash  = h;
               a.found = (e.tag == h);
               a.score = a.found ? e.score : '0;
               a.depth = a.found ? e.depth : '0;
               probe_answers.push_back(a);
            end
         end
      end
   endtask

   task automatic check_probe_answer();
      probe_answer_type a;
      if (probe_answers.size() == 0) begin
         $error("response item with no probe outstanding: entry_hash %h", rsp.entry_hash);
         error_count++;
      end else begin
         a = probe_answers.pop_front();
         if (rsp.found !== a.found) begin
            $error("found mismatch: expected %0d, actual %0d", a.found, rsp.found);
            error_count++;
         end
         if (rsp.entry_hash !== a.hash) begin
            $error("entry_hash mismatch: expected %h, actual %h", a.hash, rsp.entry_hash);
            error_count++;
         end
         if (rsp.entry_score !== a.score) begin
            $error("entry_score mismatch: expected %0d, actual %0d", a.score, rsp.entry_score);
            error_count++;
         end
         if (rsp.entry_depth !== a.depth) begin
            $error("entry_depth mismatch: expected %0d, actual %0d", a.depth, rsp.entry_depth);
            error_count++;
         end
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         position_hash = '0;
         table_mem.delete();
         probe_answers.delete();
      end else begin
         if (rsp.valid === 1'b1 && rsp.ready === 1'b1) check_probe_answer();
         if (req.valid === 1'b1 && req.ready === 1'b1) hash_and_lookup();
      end
      answers_due = probe_answers.size();
   end

endmodule

// ===== tb/sv/zobrist_transposition_table_tb.sv =====
// top of the zobrist transposition table testbench: clock, reset, item stimulus
// and response back-pressure; the verdict comes from ztt_probe_checker
// depends on ztt_pkg, ztt_ifs, zobrist_transposition_table and ztt_probe_checker

module zobrist_transposition_table_tb;
   timeunit 1ns;
   timeprecision 1ps;
   import ztt_pkg::*;

   localparam int INDEX_BITS  = 16;
   localparam int PIECE_CODES = 9;
   localparam int SQUARES     = 64;
   localparam int ITEM_TARGET = 1100;
   localparam int QUIET_FROM  = 300;
   localparam int QUIET_TO    = 550;
   localparam int HOLD_AT     = 750;
   localparam int HOLD_CYCLES = 400;
   localparam int SAVED_MAX   = 64;
   localparam int MAX_SQUARES = 16;

   logic clock;
   logic reset;
   int   fail_count;
   int   outstanding;
   int   items_sent = 0;
   logic quiet;
   bit   held_off = 0;

   bit          mask_loaded [2048];
   logic [10:0] loaded_keys [$];
   logic [10:0] pos_keys [$];
   logic [10:0] saved_keys [SAVED_MAX][MAX_SQUARES];
   int          saved_len [SAVED_MAX];
   int          saved_count = 0;
   int          saved_next = 0;

   ztt_req_if req_ch ();
   ztt_rsp_if rsp_ch ();

   zobrist_transposition_table #(
      .INDEX_BITS (INDEX_BITS),
      .PIECE_CODES(PIECE_CODES),
      .SQUARES    (SQUARES)
   ) u_dut (
      .clock(clock),
      .reset(reset),
      .req  (req_ch),
      .rsp  (rsp_ch)
   );

   ztt_probe_checker #(
      .INDEX_BITS (INDEX_BITS),
      .PIECE_CODES(PIECE_CODES),
      .SQUARES    (SQUARES)
   ) u_checker (
      .clock  (clock),
      .reset  (reset),
      .req    (req_ch),
      .rsp    (rsp_ch),
      .errors (fail_count),
      .pending(outstanding)
   );

   assign quiet = (items_sent >= QUIET_FROM) && (items_sent < QUIET_TO);

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #5_000_000;
      $display("TEST FAILED");
      $finish;
   end

   function automatic logic [10:0] key_of(int sq, int pc, int col);
      return {6'(sq), 4'(pc), 1'(col)};
   endfunction

   function automatic logic [63:0] rand64();
      return {$urandom, $urandom};
   endfunction

   task automatic send_item(logic [1:0] kind, logic [10:0] key, logic last,
                            logic [63:0] mval, logic [15:0] sc, logic [7:0] dp);
      while (!quiet && $urandom_range(99) < 32) begin
         req_ch.valid = 1'b0;
         @(negedge clock);
      end
      req_ch.valid        = 1'b1;
      req_ch.req_type     = kind;
      req_ch.square       = key[10:5];
      req_ch.piece        = key[4:1];
      req_ch.color        = key[0];
      req_ch.last_square  = last;
      req_ch.mask_value   = mval;
      req_ch.score        = sc;
      req_ch.search_depth = dp;
      @(posedge clock);
      while (req_ch.ready !== 1'b1) @(posedge clock);
      items_sent++;
      @(negedge clock);
   endtask

   task automatic load_mask(logic [10:0] key, logic [63:0] value);
      send_item(REQ_LOAD, key, 1'($urandom), value, 16'($urandom), 8'($urandom));
      if (key[4:1] < PIECE_CODES && key[10:5] < SQUARES && !mask_loaded[key]) begin
         mask_loaded[key] = 1'b1;
         loaded_keys.push_back(key);
      end
   endtask

   // last item carries final_kind; earlier ones may mix kinds, with stray unused items
   task automatic send_position(logic [1:0] final_kind, bit mixed,
                                logic [15:0] sc, logic [7:0] dp);
      logic [1:0] kind;
      bit         last;
      for (int i = 0; i < pos_keys.size(); i++) begin
         last = (i == pos_keys.size() - 1);
         kind = final_kind;
         if (mixed && !last) kind = $urandom_range(1) ? REQ_STORE : REQ_PROBE;
         if ($urandom_range(99) < 4)
            send_item(REQ_NONE, 11'($urandom), 1'($urandom), rand64(),
                      16'($urandom), 8'($urandom));
         send_item(kind, pos_keys[i], last, rand64(),
                   last ? sc : 16'($urandom), last ? dp : 8'($urandom));
      end
   endtask

   initial begin
      rsp_ch.ready = 1'b0;
      @(negedge clock);
      forever begin
         if (!held_off && items_sent >= HOLD_AT) begin
            held_off = 1'b1;
            rsp_ch.ready = 1'b0;
            repeat (HOLD_CYCLES) @(negedge clock);
         end
         rsp_ch.ready = quiet || ($urandom_range(99) >= 32);
         @(negedge clock);
      end
   end

   initial begin
      int          r;
      int          n;
      int          j;
      int          counted;
      logic [1:0]  kind;
      bit          mixed;
      logic [10:0] key;
      req_ch.valid        = 1'b0;
      req_ch.req_type     = REQ_NONE;
      req_ch.square       = '0;
      req_ch.piece        = '0;
      req_ch.color        = 1'b0;
      req_ch.last_square  = 1'b0;
      req_ch.mask_value   = '0;
      req_ch.score        = '0;
      req_ch.search_depth = '0;
      reset = 1'b1;
      repeat (7) @(negedge clock);
      reset = 1'b0;

      load_mask(key_of(0, 0, 0), '1);
      load_mask(key_of(63, 8, 1), 64'h8000_0000_0000_0001);
      load_mask(key_of(5, 3, 0), 64'h0000_0000_0000_1234);
      load_mask(key_of(6, 3, 0), 64'h0000_0100_0000_1234);
      load_mask(key_of(7, 15, 1), '1);
      send_item(REQ_NONE, key_of(0, 0, 0), 1'b1, '1, 16'h7fff, 8'hff);
      // zero hash lands on the cleared entry at index zero
      pos_keys = '{key_of(2, 9, 0)};
      send_position(REQ_PROBE, 1'b0, 16'h0000, 8'h00);
      pos_keys = '{key_of(0, 0, 0), key_of(63, 8, 1)};
      send_position(REQ_STORE, 1'b0, 16'h8000, 8'hff);
      send_position(REQ_PROBE, 1'b0, 16'h1111, 8'h11);
      pos_keys = '{key_of(5, 3, 0)};
      send_position(REQ_STORE, 1'b0, 16'h7fff, 8'h00);
      // same index, different tag
      pos_keys = '{key_of(6, 3, 0)};
      send_position(REQ_PROBE, 1'b0, 16'h0000, 8'h00);
      send_item(REQ_PROBE, key_of(5, 3, 0), 1'b0, rand64(), 16'($urandom), 8'($urandom));
      send_item(REQ_STORE, key_of(6, 3, 0), 1'b1, rand64(), 16'h0005, 8'h05);
      // repeated square cancels out
      send_item(REQ_STORE, key_of(5, 3, 0), 1'b0, rand64(), 16'($urandom), 8'($urandom));
      send_item(REQ_PROBE, key_of(5, 3, 0), 1'b1, rand64(), 16'($urandom), 8'($urandom));
      pos_keys = '{key_of(6, 3, 0), key_of(5, 3, 0)};
      send_position(REQ_PROBE, 1'b0, 16'h0000, 8'h00);
      pos_keys = '{key_of(0, 0, 0), key_of(63, 8, 1)};
      send_position(REQ_PROBE, 1'b0, 16'h0000, 8'h00);

      repeat (40)
         load_mask(key_of($urandom_range(SQUARES - 1), $urandom_range(PIECE_CODES - 1),
                          $urandom_range(1)), rand64());
      counted = items_sent;

      while (counted < ITEM_TARGET) begin
         r = $urandom_range(99);
         if (r < 12) begin
            load_mask(key_of($urandom_range(63),
                             ($urandom_range(99) < 85) ? $urandom_range(PIECE_CODES - 1)
                                                       : $urandom_range(15),
                             $urandom_range(1)), rand64());
            counted++;
         end else if (r < 15) begin
            send_item(REQ_NONE, 11'($urandom), 1'($urandom), rand64(),
                      16'($urandom), 8'($urandom));
         end else begin
            pos_keys.delete();
            if (saved_count > 0 && $urandom_range(99) < 40) begin
               j = $urandom_range(saved_count - 1);
               for (int i = 0; i < saved_len[j]; i++) pos_keys.push_back(saved_keys[j][i]);
               kind  = ($urandom_range(99) < 15) ? REQ_STORE : REQ_PROBE;
               mixed = 1'b0;
            end else begin
               n = ($urandom_range(99) < 10) ? $urandom_range(7, MAX_SQUARES)
                                             : $urandom_range(1, 6);
               repeat (n) begin
                  if ($urandom_range(99) < 8)
                     key = key_of($urandom_range(63), $urandom_range(PIECE_CODES, 15),
                                  $urandom_range(1));
                  else
                     key = loaded_keys[$urandom_range(loaded_keys.size() - 1)];
                  pos_keys.push_back(key);
               end
               kind  = $urandom_range(1) ? REQ_STORE : REQ_PROBE;
               mixed = ($urandom_range(99) < 15);
            end
            send_position(kind, mixed, 16'($urandom), 8'($urandom));
            if (kind == REQ_STORE) begin
               for (int i = 0; i < pos_keys.size(); i++)
                  saved_keys[saved_next][i] = pos_keys[i];
               saved_len[saved_next] = pos_keys.size();
               saved_next = (saved_next + 1) % SAVED_MAX;
               if (saved_count < SAVED_MAX) saved_count++;
            end
            counted += pos_keys.size();
         end
      end
      req_ch.valid = 1'b0;

      while (outstanding != 0) @(posedge clock);
      repeat (10) @(posedge clock);
      if (fail_count == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule

// ===== zobrist_transposition_table.f =====
hw/rtl/ztt_pkg.sv
hw/rtl/ztt_ifs.sv
hw/rtl/ztt_mask_mem.sv
hw/rtl/ztt_table.sv
hw/rtl/zobrist_transposition_table.sv
tb/sv/ztt_probe_checker.sv
tb/sv/zobrist_transposition_table_tb.sv
